// ----- rtl/core/crxq_pkg.sv -----
// Package for the CAN receive frame queue.
// Holds sizes, operation codes and the entry and command types shared by all modules.
package crxq_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 208;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [3:0] MAX_LENGTH = 4'd8;

  typedef struct packed {
    logic [28:0] id;
    logic        ext;
    logic [3:0]  len;
    logic [63:0] payload;
    logic [63:0] stamp;
  } crxq_entry_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    crxq_entry_t       entry;
    logic              valid_res;
    logic              dropped;
    logic              notify;
    logic [7:0]        occupancy;
    logic [31:0]       drop_total;
  } crxq_cmd_t;

endpackage

// ----- rtl/core/crxq_front.sv -----
// Front end of the CAN receive frame queue: accepts items and keeps the queue bookkeeping.
// Extends timestamps, decides store, drop or read, and issues commands. Uses crxq_pkg.
module crxq_front
  import crxq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // ext_flag, std_id, ext_id, dlc, payload, raw_stamp (from bit 0 up)
  input  logic [IN_DATA_W-1:0] in_tdata,
  // op
  input  logic                 in_tuser,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output crxq_cmd_t            cmd
);

  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [ADDR_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [15:0]       prev_raw_r, prev_raw_nxt;
  logic [47:0]       high_r, high_nxt;
  logic [31:0]       drop_r, drop_nxt;

  logic        accept;
  logic        is_ext;
  logic [10:0] std_id;
  logic [28:0] ext_id;
  logic [3:0]  dlc;
  logic [63:0] payload;
  logic [15:0] raw_stamp;
  logic        full;
  logic        empty;

  assign is_ext    = in_tdata[0];
  assign std_id    = in_tdata[11:1];
  assign ext_id    = in_tdata[40:12];
  assign dlc       = in_tdata[44:41];
  assign payload   = in_tdata[108:45];
  assign raw_stamp = in_tdata[124:109];

  assign in_tready = cmd_ready;
  assign cmd_valid = in_tvalid;
  assign accept    = in_tvalid && cmd_ready;
  assign full      = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign empty     = (fill_r == '0);

  always_comb begin
    rd_idx_nxt   = rd_idx_r;
    wr_idx_nxt   = wr_idx_r;
    fill_nxt     = fill_r;
    prev_raw_nxt = prev_raw_r;
    high_nxt     = high_r;
    drop_nxt     = drop_r;

    cmd               = '0;
    cmd.entry.id      = is_ext ? ext_id : {18'd0, std_id};
    cmd.entry.ext     = is_ext;
    cmd.entry.len     = (dlc > MAX_LENGTH) ? MAX_LENGTH : dlc;
    cmd.entry.payload = payload;

    if (in_tuser == OP_PUSH) begin
      if (raw_stamp < prev_raw_r) begin
        high_nxt = high_r + 48'd1;
      end
      prev_raw_nxt    = raw_stamp;
      cmd.entry.stamp = {high_nxt, raw_stamp};
      if (full) begin
        drop_nxt    = drop_r + 32'd1;
        cmd.dropped = 1'b1;
      end else begin
        cmd.wr_en     = 1'b1;
        cmd.addr      = wr_idx_r;
        cmd.valid_res = 1'b1;
        wr_idx_nxt    = (wr_idx_r == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_r + ADDR_W'(1);
        fill_nxt      = fill_r + FILL_W'(1);
      end
      cmd.notify = (fill_nxt != '0);
    end else if (!empty) begin
      cmd.rd_en     = 1'b1;
      cmd.addr      = rd_idx_r;
      cmd.valid_res = 1'b1;
      rd_idx_nxt    = (rd_idx_r == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_r + ADDR_W'(1);
      fill_nxt      = fill_r - FILL_W'(1);
    end

    cmd.occupancy  = 8'(fill_nxt);
    cmd.drop_total = drop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r   <= '0;
      wr_idx_r   <= '0;
      fill_r     <= '0;
      prev_raw_r <= '0;
      high_r     <= '0;
      drop_r     <= '0;
    end else if (accept) begin
      rd_idx_r   <= rd_idx_nxt;
      wr_idx_r   <= wr_idx_nxt;
      fill_r     <= fill_nxt;
      prev_raw_r <= prev_raw_nxt;
      high_r     <= high_nxt;
      drop_r     <= drop_nxt;
    end
  end

endmodule

// ----- rtl/core/crxq_cmdq.sv -----
// Two-entry command queue between the front end and the back end of the frame queue.
// Lets either side stall on its own. Uses crxq_pkg for the command type.
module crxq_cmdq
  import crxq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  crxq_cmd_t push_cmd,
  output logic      pop_valid,
  input  logic      pop_ready,
  output crxq_cmd_t pop_cmd
);

  crxq_cmd_t  cmd_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_cmd    = cmd_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      cmd_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/core/crxq_back.sv -----
// Back end of the CAN receive frame queue: frame memory and output register.
// Carries out write and read commands in order and forms result items. Uses crxq_pkg.
module crxq_back
  import crxq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  crxq_cmd_t             cmd,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // valid_res, dropped, notify, out_id, out_extended, out_length, out_payload,
  // out_stamp, occupancy, drop_total (from bit 0 up)
  output logic [OUT_DATA_W-1:0] out_tdata
);

  crxq_entry_t mem_r [QUEUE_DEPTH];
  crxq_entry_t rd_data_r;
  crxq_entry_t frame;

  logic        s_valid_r, s_valid_nxt;
  logic        s_rd_r;
  logic        s_valid_res_r;
  logic        s_dropped_r;
  logic        s_notify_r;
  logic [7:0]  s_occ_r;
  logic [31:0] s_drop_r;
  logic        advance;
  logic        issue;

  assign advance     = !s_valid_r || out_tready;
  assign cmd_ready   = advance;
  assign issue       = cmd_valid && advance;
  assign s_valid_nxt = advance ? cmd_valid : s_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s_rd_r        <= cmd.rd_en;
      s_valid_res_r <= cmd.valid_res;
      s_dropped_r   <= cmd.dropped;
      s_notify_r    <= cmd.notify;
      s_occ_r       <= cmd.occupancy;
      s_drop_r      <= cmd.drop_total;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && cmd.wr_en) begin
      mem_r[cmd.addr] <= cmd.entry;
    end
    if (issue && cmd.rd_en) begin
      rd_data_r <= mem_r[cmd.addr];
    end
  end

  assign frame      = s_rd_r ? rd_data_r : '0;
  assign out_tvalid = s_valid_r;
  assign out_tdata  = {3'b000, s_drop_r, s_occ_r, frame.stamp, frame.payload, frame.len,
                       frame.ext, frame.id, s_notify_r, s_dropped_r, s_valid_res_r};

endmodule

// ----- rtl/core/can_rx_frame_queue.sv -----
// Receive queue for CAN frames: accepts one push or pop item per cycle and gives one result each.
// A result is registered first in the command queue, then in the memory read and output registers.
// Throughput is one item per cycle while the result side takes items.
// Reset clears the pointers, fill level, timestamp extension and drop counter.
// The frame memory is not cleared and has no clearing pass; only written entries are read.
module can_rx_frame_queue
  import crxq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // ext_flag, std_id, ext_id, dlc, payload, raw_stamp (from bit 0 up)
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // op
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // valid_res, dropped, notify, out_id, out_extended, out_length, out_payload,
  // out_stamp, occupancy, drop_total (from bit 0 up)
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic      f_valid;
  logic      f_ready;
  crxq_cmd_t f_cmd;
  logic      b_valid;
  logic      b_ready;
  crxq_cmd_t b_cmd;

  crxq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  crxq_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_cmd    (b_cmd)
  );

  crxq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (b_valid),
    .cmd_ready  (b_ready),
    .cmd        (b_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
